FILE: src/u2u_pkg.sv
// Shared types, character codes and encode helpers for the UTF-16 to
// escaped UTF-8 literal block. No dependencies.
package u2u_pkg;

   localparam logic [6:0] CH_QUOTE  = 7'h22;
   localparam logic [6:0] CH_BSLASH = 7'h5C;
   localparam logic [6:0] CH_X      = 7'h78;
   localparam logic [6:0] CH_ZERO   = 7'h30;
   // Upper-case 'A' minus ten, so that digit values 10..15 map onto A..F.
   localparam logic [6:0] CH_HEX_AF = 7'h37;

   localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

   // How one UTF-8 byte is written: as itself, behind a backslash, or as \xHH.
   typedef enum logic [1:0] {
      TOK_PLAIN = 2'd0,
      TOK_ESC   = 2'd1,
      TOK_HEX   = 2'd2
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   val;
   } token_type;

   localparam token_type TOK_NONE = '{kind: TOK_PLAIN, val: 8'h00};

   // Encoding of one unit that is not part of a pair: one to three tokens.
   typedef struct packed {
      logic [1:0]      cnt;
      token_type [2:0] tok;
   } enc_type;

   // Work for one item: optional quotes around group A (held unit or pair)
   // and group B (the new unit).
   typedef struct packed {
      logic            open_q;
      logic            close_q;
      logic [2:0]      a_cnt;
      token_type [3:0] a_tok;
      logic [1:0]      b_cnt;
      token_type [2:0] b_tok;
   } desc_type;

   typedef struct packed {
      logic     push;
      desc_type desc;
   } q_wr_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } q_rd_type;

   function automatic token_type mk_tok(input tok_kind_type kind, input logic [7:0] val);
      token_type t;
      t.kind = kind;
      t.val  = val;
      return t;
   endfunction

   function automatic enc_type enc_single(input logic [15:0] c);
      enc_type e;
      e.cnt = 2'd0;
      e.tok = {TOK_NONE, TOK_NONE, TOK_NONE};
      if (c >= 16'h0020 && c <= 16'h007E) begin
         e.cnt = 2'd1;
         if (c[6:0] == CH_QUOTE || c[6:0] == CH_BSLASH) begin
            e.tok[0] = mk_tok(TOK_ESC, c[7:0]);
         end else begin
            e.tok[0] = mk_tok(TOK_PLAIN, c[7:0]);
         end
      end else if (c < 16'h0080) begin
         e.cnt    = 2'd1;
         e.tok[0] = mk_tok(TOK_HEX, c[7:0]);
      end else if (c < 16'h0800) begin
         e.cnt    = 2'd2;
         e.tok[0] = mk_tok(TOK_HEX, {3'b110, c[10:6]});
         e.tok[1] = mk_tok(TOK_HEX, {2'b10, c[5:0]});
      end else begin
         e.cnt    = 2'd3;
         e.tok[0] = mk_tok(TOK_HEX, {4'hE, c[15:12]});
         e.tok[1] = mk_tok(TOK_HEX, {2'b10, c[11:6]});
         e.tok[2] = mk_tok(TOK_HEX, {2'b10, c[5:0]});
      end
      return e;
   endfunction

   function automatic logic [6:0] hex_char(input logic [3:0] v);
      logic [6:0] ch;
      if (v < 4'd10) begin
         ch = CH_ZERO + {3'b000, v};
      end else begin
         ch = CH_HEX_AF + {3'b000, v};
      end
      return ch;
   endfunction

endpackage

FILE: src/u2u_ifs.sv
// Valid/ready channel interfaces for the code-unit input and the character
// output. No dependencies.
interface u2u_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        first_unit;
   logic        last_unit;

   modport source (output valid, code_unit, first_unit, last_unit, input ready);
   modport sink   (input valid, code_unit, first_unit, last_unit, output ready);
endinterface

interface u2u_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       out_last;

   modport source (output valid, out_char, out_last, input ready);
   modport sink   (input valid, out_char, out_last, output ready);
endinterface

FILE: src/u2u_front.sv
// Front end: accepts code units, pairs surrogates and builds at most one work
// descriptor per item. Depends on u2u_pkg and u2u_req_if.
module u2u_front (
   input  logic              clock,
   input  logic              reset,
   u2u_req_if.sink           req_ch,
   input  logic              q_full,
   output u2u_pkg::q_wr_type q_wr
);

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_payload_ff, held_payload_in;

   logic              accept;
   logic              held_eff;
   logic              is_low;
   logic              is_high;
   logic              pair_use;
   logic              hold_new;
   logic [10:0]       plane;
   u2u_pkg::enc_type  enc_held;
   u2u_pkg::enc_type  enc_new;
   u2u_pkg::desc_type desc;

   assign req_ch.ready = ~q_full;
   assign accept       = req_ch.valid & ~q_full;

   always_comb begin
      // A unit that opens a string drops whatever the previous string held.
      held_eff = held_valid_ff & ~req_ch.first_unit;
      is_low   = (req_ch.code_unit[15:10] == u2u_pkg::SURR_LOW_TAG);
      is_high  = (req_ch.code_unit[15:10] == u2u_pkg::SURR_HIGH_TAG);
      pair_use = held_eff & is_low;
      hold_new = ~pair_use & is_high & ~req_ch.last_unit;
      plane    = {1'b0, held_payload_ff} + 11'h040;
      enc_held = u2u_pkg::enc_single({u2u_pkg::SURR_HIGH_TAG, held_payload_ff});
      enc_new  = u2u_pkg::enc_single(req_ch.code_unit);

      desc.open_q  = req_ch.first_unit;
      desc.close_q = req_ch.last_unit;
      if (pair_use) begin
         desc.a_cnt    = 3'd4;
         desc.a_tok[0] = u2u_pkg::mk_tok(u2u_pkg::TOK_HEX, {5'b11110, plane[10:8]});
         desc.a_tok[1] = u2u_pkg::mk_tok(u2u_pkg::TOK_HEX, {2'b10, plane[7:2]});
         desc.a_tok[2] = u2u_pkg::mk_tok(u2u_pkg::TOK_HEX,
                                         {2'b10, plane[1:0], req_ch.code_unit[9:6]});
         desc.a_tok[3] = u2u_pkg::mk_tok(u2u_pkg::TOK_HEX,
                                         {2'b10, req_ch.code_unit[5:0]});
      end else if (held_eff) begin
         desc.a_cnt = {1'b0, enc_held.cnt};
         desc.a_tok = {u2u_pkg::TOK_NONE, enc_held.tok};
      end else begin
         desc.a_cnt = 3'd0;
         desc.a_tok = {u2u_pkg::TOK_NONE, u2u_pkg::TOK_NONE,
                       u2u_pkg::TOK_NONE, u2u_pkg::TOK_NONE};
      end

      if (pair_use || hold_new) begin
         desc.b_cnt = 2'd0;
         desc.b_tok = {u2u_pkg::TOK_NONE, u2u_pkg::TOK_NONE, u2u_pkg::TOK_NONE};
      end else begin
         desc.b_cnt = enc_new.cnt;
         desc.b_tok = enc_new.tok;
      end

      // An item that only parks a high surrogate has nothing to print.
      q_wr.push = accept & (desc.open_q | desc.close_q | (desc.a_cnt != 3'd0) |
                            (desc.b_cnt != 2'd0));
      q_wr.desc = desc;

      held_valid_in   = held_valid_ff;
      held_payload_in = held_payload_ff;
      if (accept) begin
         held_valid_in   = hold_new;
         held_payload_in = hold_new ? req_ch.code_unit[9:0] : 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff   <= 1'b0;
         held_payload_ff <= 10'd0;
      end else begin
         held_valid_ff   <= held_valid_in;
         held_payload_ff <= held_payload_in;
      end
   end

endmodule

FILE: src/u2u_queue.sv
// Short descriptor queue between the front and back ends.
// Depends on u2u_pkg.
module u2u_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  u2u_pkg::q_wr_type q_wr,
   input  logic              pop,
   output logic              q_full,
   output u2u_pkg::q_rd_type q_rd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   u2u_pkg::desc_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign q_full     = (cnt_ff == CNT_W'(DEPTH));
   assign q_rd.valid = (cnt_ff != '0);
   assign q_rd.desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (q_wr.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(q_wr.push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (q_wr.push) begin
         entry_ff[wr_ptr_ff] <= q_wr.desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_wr.push |-> !q_full)
      else $error("descriptor pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_rd.valid)
      else $error("descriptor popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

FILE: src/u2u_back.sv
// Back end: walks each descriptor and writes one literal character per cycle
// into the output register while the receiver keeps up. Depends on u2u_pkg and u2u_rsp_if.
module u2u_back (
   input  logic              clock,
   input  logic              reset,
   input  u2u_pkg::q_rd_type q_rd,
   output logic              pop,
   u2u_rsp_if.source         rsp_ch
);

   typedef enum logic [4:0] {
      SEG_OPEN  = 5'b00001,
      SEG_A     = 5'b00010,
      SEG_B     = 5'b00100,
      SEG_CLOSE = 5'b01000,
      SEG_NONE  = 5'b10000
   } seg_type;

   seg_type    seg_ff, seg_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] sub_ff, sub_in;
   logic       fresh_ff, fresh_in;
   logic       out_valid_ff, out_valid_in;
   logic [6:0] out_char_ff, out_char_in;
   logic       out_last_ff, out_last_in;

   u2u_pkg::desc_type  d;
   u2u_pkg::token_type tok;
   seg_type            cur_seg;
   seg_type            nxt_seg;
   logic [1:0]         cur_idx;
   logic [1:0]         cur_sub;
   logic [1:0]         tok_end_sub;
   logic               step;
   logic               end_tok;
   logic               end_seg;
   logic               final_char;
   logic [6:0]         ch;

   function automatic seg_type seg_after(input u2u_pkg::desc_type x, input seg_type s);
      seg_type r;
      r = SEG_NONE;
      case (s)
         SEG_OPEN: begin
            if (x.a_cnt != 3'd0) r = SEG_A;
            else if (x.b_cnt != 2'd0) r = SEG_B;
            else if (x.close_q) r = SEG_CLOSE;
         end
         SEG_A: begin
            if (x.b_cnt != 2'd0) r = SEG_B;
            else if (x.close_q) r = SEG_CLOSE;
         end
         SEG_B: begin
            if (x.close_q) r = SEG_CLOSE;
         end
         default: r = SEG_NONE;
      endcase
      return r;
   endfunction

   assign d    = q_rd.desc;
   assign step = q_rd.valid & (~out_valid_ff | rsp_ch.ready);

   always_comb begin
      // A fresh descriptor starts at its first segment that has any output.
      if (fresh_ff) begin
         cur_seg = d.open_q ? SEG_OPEN : seg_after(d, SEG_OPEN);
         cur_idx = 2'd0;
         cur_sub = 2'd0;
      end else begin
         cur_seg = seg_ff;
         cur_idx = idx_ff;
         cur_sub = sub_ff;
      end

      tok = (cur_seg == SEG_A) ? d.a_tok[cur_idx] : d.b_tok[cur_idx];

      tok_end_sub = 2'd0;
      ch          = u2u_pkg::CH_QUOTE;
      if (cur_seg == SEG_A || cur_seg == SEG_B) begin
         case (tok.kind)
            u2u_pkg::TOK_PLAIN: begin
               tok_end_sub = 2'd0;
               ch          = tok.val[6:0];
            end
            u2u_pkg::TOK_ESC: begin
               tok_end_sub = 2'd1;
               ch          = (cur_sub == 2'd0) ? u2u_pkg::CH_BSLASH : tok.val[6:0];
            end
            u2u_pkg::TOK_HEX: begin
               tok_end_sub = 2'd3;
               case (cur_sub)
                  2'd0:    ch = u2u_pkg::CH_BSLASH;
                  2'd1:    ch = u2u_pkg::CH_X;
                  2'd2:    ch = u2u_pkg::hex_char(tok.val[7:4]);
                  default: ch = u2u_pkg::hex_char(tok.val[3:0]);
               endcase
            end
            default: begin
               tok_end_sub = 2'd0;
               ch          = tok.val[6:0];
            end
         endcase
      end

      end_tok = (cur_sub == tok_end_sub);
      case (cur_seg)
         SEG_A:   end_seg = end_tok & (({1'b0, cur_idx} + 3'd1) == d.a_cnt);
         SEG_B:   end_seg = end_tok & ((cur_idx + 2'd1) == d.b_cnt);
         default: end_seg = 1'b1;
      endcase
      nxt_seg    = seg_after(d, cur_seg);
      final_char = end_seg & (nxt_seg == SEG_NONE);

      pop          = step & final_char;
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      sub_in       = sub_ff;
      fresh_in     = fresh_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      if (step) begin
         out_valid_in = 1'b1;
         out_char_in  = ch;
         out_last_in  = final_char;
         if (final_char) begin
            fresh_in = 1'b1;
         end else if (end_seg) begin
            fresh_in = 1'b0;
            seg_in   = nxt_seg;
            idx_in   = 2'd0;
            sub_in   = 2'd0;
         end else if (end_tok) begin
            fresh_in = 1'b0;
            seg_in   = cur_seg;
            idx_in   = cur_idx + 2'd1;
            sub_in   = 2'd0;
         end else begin
            fresh_in = 1'b0;
            seg_in   = cur_seg;
            idx_in   = cur_idx;
            sub_in   = cur_sub + 2'd1;
         end
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= SEG_OPEN;
         idx_ff       <= 2'd0;
         sub_ff       <= 2'd0;
         fresh_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         sub_ff       <= sub_in;
         fresh_ff     <= fresh_in;
         out_valid_ff <= out_valid_in;
      end
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_char = out_char_ff;
   assign rsp_ch.out_last = out_last_ff;

endmodule

FILE: src/utf16_to_utf8_escaped_literal.sv
// Top level of the UTF-16 to escaped UTF-8 C string literal block.
// Depends on u2u_pkg, u2u_ifs, u2u_front, u2u_queue and u2u_back.
//
// Usage: req_ch carries one UTF-16 code unit per item with first_unit and
// last_unit marking the ends of a string. rsp_ch carries the literal text, one
// ASCII character per item, with out_last set on the final character that an
// input item causes. Both channels transfer on valid and ready high together.
//
// Throughput: the back end writes one character per cycle while the receiver
// keeps up, and an input item causes 1 to 25 characters (up to 12 for a
// non-ASCII unit plus the quotes, or 16 for a surrogate pair). A unit that only
// parks a high surrogate produces no characters. The front end accepts one
// item per cycle while the descriptor queue (QUEUE_DEPTH entries) has room,
// so it runs ahead of the back end.
// Path: with the queue and output register empty, an accepted item is written
// into the descriptor queue, then its first character into the output register.
// Reset clears the held surrogate, the queue and the output register.
// When the receiver stalls, the output register holds its character and the
// queue fills; once it is full req_ch.ready drops.
module utf16_to_utf8_escaped_literal #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   u2u_req_if.sink   req_ch,
   u2u_rsp_if.source rsp_ch
);

   u2u_pkg::q_wr_type q_wr;
   u2u_pkg::q_rd_type q_rd;
   logic              q_full;
   logic              pop;

   u2u_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_wr   (q_wr)
   );

   u2u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .pop    (pop),
      .q_full (q_full),
      .q_rd   (q_rd)
   );

   u2u_back u_back (
      .clock  (clock),
      .reset  (reset),
      .q_rd   (q_rd),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the UTF-16 to escaped UTF-8 literal block.
// Depends on u2u_pkg, u2u_ifs and the RTL top utf16_to_utf8_escaped_literal.
// Directed table first, then random strings checked against an in-bench predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int UNIT_TARGET    = 430;
   localparam int IDLE_LIMIT     = 3000;
   localparam int HOLD_OFF       = 400;
   localparam int DRAIN_CYCLES   = 20;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [6:0] CH_UPPER_A = 7'h41;

   typedef struct {
      logic [15:0] unit;
      bit          first;
      bit          last;
      bit          typed;
      string       text;
   } unit_row_type;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } lit_char_type;

   logic clock;
   logic reset;

   u2u_req_if req_ch ();
   u2u_rsp_if rsp_ch ();

   utf16_to_utf8_escaped_literal i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Directed strings. Rows with typed set carry the literal text they must produce.
   unit_row_type directed_rows [25] = '{
      '{16'h0041, 1, 1, 1, "\"A\""},
      '{16'h0000, 1, 0, 1, "\"\\x00"},
      '{16'h007E, 0, 0, 1, "~"},
      '{16'h0022, 0, 0, 1, "\\\""},
      '{16'h005C, 0, 0, 1, "\\\\"},
      '{16'h0020, 0, 0, 1, " "},
      '{16'h001F, 0, 0, 1, "\\x1F"},
      '{16'h007F, 0, 0, 1, "\\x7F"},
      '{16'h0080, 0, 0, 1, "\\xC2\\x80"},
      '{16'h07FF, 0, 0, 1, "\\xDF\\xBF"},
      '{16'h0800, 0, 0, 1, "\\xE0\\xA0\\x80"},
      '{16'hFFFF, 0, 0, 1, "\\xEF\\xBF\\xBF"},
      '{16'hD800, 0, 0, 1, ""},
      '{16'hDC00, 0, 0, 1, "\\xF0\\x90\\x80\\x80"},
      '{16'hDBFF, 0, 0, 1, ""},
      '{16'hDFFF, 0, 1, 1, "\\xF4\\x8F\\xBF\\xBF\""},
      '{16'hDBFF, 1, 0, 1, "\""},
      '{16'h0041, 0, 0, 0, ""},
      '{16'hDC00, 0, 0, 0, ""},
      '{16'hD800, 0, 0, 1, ""},
      '{16'h0042, 1, 0, 0, ""},
      '{16'hD801, 0, 0, 1, ""},
      '{16'hD83D, 0, 0, 0, ""},
      '{16'hDA00, 0, 1, 0, ""},
      '{16'hDC00, 1, 1, 0, ""}
   };

   unit_row_type  unit_queue [$];
   lit_char_type  pending_chars [$];
   logic [6:0]    step_chars [$];

   // Predictor state: a high surrogate waiting for its partner.
   bit         surr_held;
   logic [9:0] surr_payload;

   int accepted_units;
   int checked_chars;
   int mismatch_count;
   int idle_cycles;
   int string_count;
   bit hold_off_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void add_char(input logic [6:0] ch);
      step_chars.insert(step_chars.size(), ch);
   endfunction

   function automatic logic [6:0] hex_digit_char(input logic [3:0] nib);
      if (nib < 4'd10) return u2u_pkg::CH_ZERO + 7'(nib);
      return CH_UPPER_A + 7'(nib) - 7'd10;
   endfunction

   function automatic void emit_utf8_byte(input logic [7:0] b);
      add_char(u2u_pkg::CH_BSLASH);
      add_char(u2u_pkg::CH_X);
      add_char(hex_digit_char(b[7:4]));
      add_char(hex_digit_char(b[3:0]));
   endfunction

   // Escapes one unit that is not half of a surrogate pair.
   function automatic void encode_unit(input logic [15:0] c);
      if (c >= 16'h0020 && c <= 16'h007E) begin
         if (c[6:0] == u2u_pkg::CH_QUOTE || c[6:0] == u2u_pkg::CH_BSLASH)
            add_char(u2u_pkg::CH_BSLASH);
         add_char(c[6:0]);
      end else if (c < 16'h0080) begin
         emit_utf8_byte(c[7:0]);
      end else if (c < 16'h0800) begin
         emit_utf8_byte({3'b110, c[10:6]});
         emit_utf8_byte({2'b10, c[5:0]});
      end else begin
         emit_utf8_byte({4'hE, c[15:12]});
         emit_utf8_byte({2'b10, c[11:6]});
         emit_utf8_byte({2'b10, c[5:0]});
      end
   endfunction

   // Works out the literal characters for one accepted unit and updates the held surrogate.
   function automatic void predict_literal(input logic [15:0] c, input bit first,
                                           input bit last);
      logic [20:0] cp;
      bit paired;
      paired = 1'b0;
      step_chars.delete();
      if (first) begin
         surr_held    = 1'b0;
         surr_payload = '0;
         add_char(u2u_pkg::CH_QUOTE);
      end
      if (surr_held) begin
         if (c >= 16'hDC00 && c < 16'hE000) begin
            cp = 21'h10000 + {1'b0, surr_payload, 10'b0} + 21'(c - 16'hDC00);
            emit_utf8_byte({5'b11110, cp[20:18]});
            emit_utf8_byte({2'b10, cp[17:12]});
            emit_utf8_byte({2'b10, cp[11:6]});
            emit_utf8_byte({2'b10, cp[5:0]});
            paired = 1'b1;
         end else begin
            encode_unit({u2u_pkg::SURR_HIGH_TAG, surr_payload});
         end
         surr_held    = 1'b0;
         surr_payload = '0;
      end
      if (!paired) begin
         if (c >= 16'hD800 && c < 16'hDC00 && !last) begin
            surr_payload = c[9:0];
            surr_held    = 1'b1;
         end else begin
            encode_unit(c);
         end
      end
      if (last) add_char(u2u_pkg::CH_QUOTE);
   endfunction

   function automatic void record_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", what);
   endfunction

   function automatic void add_unit(input logic [15:0] unit, input bit first, input bit last);
      unit_row_type row;
      row.unit  = unit;
      row.first = first;
      row.last  = last;
      row.typed = 1'b0;
      row.text  = "";
      unit_queue.insert(unit_queue.size(), row);
   endfunction

   // One random string. Most are well formed; about one in eight has its markers scrambled.
   function automatic void add_random_string();
      int len;
      bit noisy;
      bit first;
      bit last;
      logic [15:0] c;
      len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : $urandom_range(1, 5);
      noisy = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < len; k++) begin
         first = (k == 0);
         last  = (k == len - 1);
         if (noisy) begin
            first = ($urandom_range(0, 3) == 0);
            last  = ($urandom_range(0, 3) == 0);
         end
         case ($urandom_range(0, 9))
            0, 1: c = 16'($urandom_range(16'h20, 16'h7E));
            2: c = ($urandom_range(0, 1) == 1) ? 16'h0022 : 16'h005C;
            3: c = ($urandom_range(0, 3) == 0) ? 16'h007F : 16'($urandom_range(0, 16'h1F));
            4: c = 16'($urandom_range(16'h80, 16'h7FF));
            5: c = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(16'h800, 16'hD7FF))
                                               : 16'($urandom_range(16'hE000, 16'hFFFF));
            6: begin
               // A proper surrogate pair: the high half goes out here.
               add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), first, 1'b0);
               first = 1'b0;
               c = 16'($urandom_range(16'hDC00, 16'hDFFF));
            end
            7: c = 16'($urandom_range(16'hD800, 16'hDBFF));
            8: c = 16'($urandom_range(16'hDC00, 16'hDFFF));
            default: c = 16'($urandom_range(0, 16'hFFFF));
         endcase
         add_unit(c, first, last);
      end
   endfunction

   // Scoreboard and watchdog, sampled at the rising edge.
   always @(posedge clock) begin
      lit_char_type want;
      unit_row_type row;
      lit_char_type lc;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            checked_chars++;
            if (pending_chars.size() == 0) begin
               record_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                         rsp_ch.out_char, rsp_ch.out_last));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_ch.out_char !== want.ch || rsp_ch.out_last !== want.last)
                  record_mismatch($sformatf(
                     "character %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                     checked_chars, want.ch, want.last, rsp_ch.out_char, rsp_ch.out_last));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            row = unit_queue[accepted_units];
            accepted_units++;
            if (req_ch.first_unit) string_count++;
            predict_literal(req_ch.code_unit, req_ch.first_unit, req_ch.last_unit);
            if (row.typed) begin
               step_chars.delete();
               for (int i = 0; i < row.text.len(); i++) add_char(7'(row.text[i]));
            end
            for (int i = 0; i < step_chars.size(); i++) begin
               lc.ch   = step_chars[i];
               lc.last = (i == step_chars.size() - 1);
               pending_chars.insert(pending_chars.size(), lc);
            end
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
               $display("tb_top failed");
               $finish;
            end
         end
      end
   end

   // Character receiver: random stalls, quiet stretches, and one long hold-off.
   initial begin
      int gap;
      int seen;
      seen = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = ((seen / 64) % 3 == 1) ? 0 : $urandom_range(0, 10);
         if (!hold_off_done && seen >= 150) begin
            // Stall long enough that the queue fills and the input side backs up.
            hold_off_done = 1'b1;
            gap = HOLD_OFF;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         seen++;
      end
   end

   // Reset, code-unit sender and end of run.
   initial begin
      int gap;
      req_ch.valid      <= 1'b0;
      req_ch.code_unit  <= '0;
      req_ch.first_unit <= 1'b0;
      req_ch.last_unit  <= 1'b0;
      reset             <= 1'b1;
      surr_held      = 1'b0;
      surr_payload   = '0;
      accepted_units = 0;
      checked_chars  = 0;
      mismatch_count = 0;
      idle_cycles    = 0;
      string_count   = 0;

      foreach (directed_rows[i]) unit_queue.insert(unit_queue.size(), directed_rows[i]);
      while (unit_queue.size() < UNIT_TARGET) add_random_string();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < unit_queue.size(); i++) begin
         gap = ((i / 50) % 3 == 2) ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_ch.valid      <= 1'b1;
         req_ch.code_unit  <= unit_queue[i].unit;
         req_ch.first_unit <= unit_queue[i].first;
         req_ch.last_unit  <= unit_queue[i].last;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
      end
      req_ch.valid <= 1'b0;

      while (accepted_units < unit_queue.size() || pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0)
         record_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));

      $display("Sent %0d code units in %0d strings, checked %0d characters.",
               accepted_units, string_count, checked_chars);
      $display("Covered surrogate pairs, unpaired halves, escapes and a %0d-cycle output stall.",
               HOLD_OFF);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
